// ===== hdl/tatpd_pkg.sv =====
package tatpd_pkg;

  // Number of entries in the arctangent table.
  localparam int TableLen = 24;

  // Angle word width (fraction of a turn).
  localparam int AngW = 32;

  // CORDIC datapath width for both units.
  localparam int DatW = 48;

  // Fixed angles and gains.
  localparam logic [31:0] ThirdTurn     = 32'd1431655765;
  localparam logic [31:0] TwoThirdsTurn = 32'd2863311531;
  localparam logic [31:0] HalfTurn      = 32'h8000_0000;
  localparam logic [31:0] QuarterTurn   = 32'h4000_0000;
  localparam logic [47:0] InvGain       = 48'd2608131496;

  // atan(2^-i) as a fraction of a turn.
  function automatic logic [31:0] atan_turn(input logic [4:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:  v = 32'd536870912;
      5'd1:  v = 32'd316933406;
      5'd2:  v = 32'd167458907;
      5'd3:  v = 32'd85004756;
      5'd4:  v = 32'd42667331;
      5'd5:  v = 32'd21354465;
      5'd6:  v = 32'd10679838;
      5'd7:  v = 32'd5340245;
      5'd8:  v = 32'd2670163;
      5'd9:  v = 32'd1335087;
      5'd10: v = 32'd667544;
      5'd11: v = 32'd333772;
      5'd12: v = 32'd166886;
      5'd13: v = 32'd83443;
      5'd14: v = 32'd41722;
      5'd15: v = 32'd20861;
      5'd16: v = 32'd10430;
      5'd17: v = 32'd5215;
      5'd18: v = 32'd2608;
      5'd19: v = 32'd1304;
      5'd20: v = 32'd652;
      5'd21: v = 32'd326;
      5'd22: v = 32'd163;
      5'd23: v = 32'd81;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== hdl/tilt_angle_to_three_phase_duty.sv =====
// Channel | Ports                           | Contents (low bit first)
// in      | in_tvalid/in_tready/in_tdata    | tilt_x, tilt_y
// out     | out_tvalid/out_tready/out_tdata | duty_first, duty_second, duty_third
// cfg     | cfg_we/cfg_wdata                | square_enable
//
// One item per cycle while the output is not stalled. Pipeline registers in order:
// entry register, the vectoring CORDIC stages, a phase register, the rotating
// stages, one multiply stage, one scaling stage and the output register.
// Reset (synchronous, rst_n low) clears all valid bits and sets square_enable.
// A stall on the output holds the whole pipeline; in_tready is low only while
// a result sits in the output register and out_tready is low.
module tilt_angle_to_three_phase_duty #(
  parameter int SAMPLE_BITS = 12,
  parameter int DUTY_BITS   = 8,
  parameter int ANGLE_STEPS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0]    in_tdata,   // tilt_x, tilt_y
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [((3*DUTY_BITS+7)/8)*8-1:0]      out_tdata,  // duty_first, duty_second, duty_third
  input  logic                                  cfg_we,
  input  logic                                  cfg_wdata   // square_enable
);

  localparam int DW    = tatpd_pkg::DatW;
  localparam int AW    = tatpd_pkg::AngW;
  localparam int NS    = (ANGLE_STEPS < tatpd_pkg::TableLen) ? ANGLE_STEPS
                                                             : tatpd_pkg::TableLen;
  localparam int NST   = 2 * NS + 4;
  localparam int OutW  = ((3*DUTY_BITS+7)/8)*8;
  localparam logic [DUTY_BITS+16:0] DMax = (DUTY_BITS+17)'((1 << DUTY_BITS) - 1);

  logic square_enable_r;
  logic [NST-1:0] vld_r;
  logic adv;
  logic out_tvalid_r;
  logic [OutW-1:0] out_tdata_r;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) square_enable_r <= 1'b1;
    else if (cfg_we) square_enable_r <= cfg_wdata;
  end

  // Whole pipeline advances unless the output register is full and stalled.
  assign adv       = !out_tvalid_r || out_tready;
  assign in_tready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NST-2:0], in_tvalid};
    end
  end

  // Entry stage: sign extend, scale by 2^30 and fold the left half plane.
  logic signed [SAMPLE_BITS-1:0] sx_w, sy_w;
  logic signed [DW-1:0] ax_w, ay_w;
  logic signed [DW-1:0] vx [NS+1];
  logic signed [DW-1:0] vy [NS+1];
  logic [AW-1:0]        vz [NS+1];
  logic zero_w;
  logic zero_r [NS+1];

  assign sx_w   = in_tdata[SAMPLE_BITS-1:0];
  assign sy_w   = in_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
  assign ay_w   = DW'(sx_w) <<< 30;
  assign ax_w   = DW'(sy_w) <<< 30;
  assign zero_w = (sx_w == '0) && (sy_w == '0);

  always_ff @(posedge clk) begin
    if (adv) begin
      if (ax_w[DW-1]) begin
        vx[0] <= -ax_w;
        vy[0] <= -ay_w;
        vz[0] <= tatpd_pkg::HalfTurn;
      end else begin
        vx[0] <= ax_w;
        vy[0] <= ay_w;
        vz[0] <= '0;
      end
      zero_r[0] <= zero_w;
    end
  end

  for (genvar i = 0; i < NS; i++) begin : g_vec
    tatpd_vec_stage #(.Step(i)) u_vec (
      .clk(clk), .adv(adv),
      .px_i(vx[i]), .py_i(vy[i]), .z_i(vz[i]),
      .px_r(vx[i+1]), .py_r(vy[i+1]), .z_r(vz[i+1])
    );
    always_ff @(posedge clk) begin
      if (adv) zero_r[i+1] <= zero_r[i];
    end
  end

  // Phase stage: round theta to 16 bits, form three phases and fold them.
  logic [AW-1:0] th_w, base_w;
  logic [AW-1:0] ph_w [3];
  logic signed [DW-1:0] rx [NS+1][3];
  logic signed [DW-1:0] ry [NS+1][3];
  logic signed [AW:0]   rr [NS+1][3];

  assign th_w     = zero_r[NS] ? '0 : vz[NS] + AW'(32'h8000);
  assign base_w   = {th_w[31:16], 16'h0000};
  assign ph_w[0]  = base_w;
  assign ph_w[1]  = base_w + tatpd_pkg::ThirdTurn;
  assign ph_w[2]  = base_w + tatpd_pkg::TwoThirdsTurn;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        logic [AW-1:0] f;
        f = ((ph_w[k] - tatpd_pkg::QuarterTurn) < tatpd_pkg::HalfTurn)
            ? (tatpd_pkg::HalfTurn - ph_w[k]) : ph_w[k];
        rx[0][k] <= tatpd_pkg::InvGain;
        ry[0][k] <= '0;
        rr[0][k] <= {f[AW-1], f};
      end
    end
  end

  for (genvar i = 0; i < NS; i++) begin : g_rot
    tatpd_rot_stage #(.Step(i)) u_rot (
      .clk(clk), .adv(adv),
      .x_i(rx[i]), .y_i(ry[i]), .r_i(rr[i]),
      .x_r(rx[i+1]), .y_r(ry[i+1]), .r_r(rr[i+1])
    );
  end

  // Multiply stage: round sine to Q1.15, map to m16 and square it.
  logic [16:0] m16_r [3];
  logic [33:0] sq_r  [3];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        logic signed [DW-1:0] s;
        logic [16:0] m;
        s = (ry[NS][k] + DW'(65536)) >>> 17;
        if (s > DW'(32767)) s = DW'(32767);
        else if (s < -DW'(32768)) s = -DW'(32768);
        m = 17'(s + DW'(32768));
        m16_r[k] <= m;
        sq_r[k]  <= 34'(m) * 34'(m);
      end
    end
  end

  // Scaling stage: multiply by the duty maximum, round and saturate.
  logic [DUTY_BITS-1:0] duty_r [3];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        logic [34+DUTY_BITS-1:0] p;
        logic [DUTY_BITS+16:0] v;
        if (square_enable_r) begin
          p = (34+DUTY_BITS)'(sq_r[k]) * (34+DUTY_BITS)'(DMax)
              + (34+DUTY_BITS)'(64'h8000_0000);
          v = (DUTY_BITS+17)'(p >> 32);
        end else begin
          p = (34+DUTY_BITS)'(m16_r[k]) * (34+DUTY_BITS)'(DMax)
              + (34+DUTY_BITS)'(32768);
          v = (DUTY_BITS+17)'(p >> 16);
        end
        duty_r[k] <= (v > DMax) ? DMax[DUTY_BITS-1:0] : v[DUTY_BITS-1:0];
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (adv) begin
      out_tvalid_r <= vld_r[NST-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) out_tdata_r <= OutW'({duty_r[2], duty_r[1], duty_r[0]});
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // Output must hold while stalled.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output item changed while stalled");

  // Pipeline must not move while the output stalls.
  a_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(vld_r))
    else $error("pipeline advanced during stall");

  // An accepted item enters the first valid bit.
  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> vld_r[0])
    else $error("accepted item lost at entry");

endmodule

// ===== hdl/tatpd_vec_stage.sv =====
// One vectoring CORDIC iteration with its pipeline register.
module tatpd_vec_stage #(
  parameter int Step = 0
) (
  input  logic                         clk,
  input  logic                         adv,
  input  logic signed [tatpd_pkg::DatW-1:0] px_i,
  input  logic signed [tatpd_pkg::DatW-1:0] py_i,
  input  logic [tatpd_pkg::AngW-1:0]   z_i,
  output logic signed [tatpd_pkg::DatW-1:0] px_r,
  output logic signed [tatpd_pkg::DatW-1:0] py_r,
  output logic [tatpd_pkg::AngW-1:0]   z_r
);

  localparam logic [4:0] Idx = 5'(Step);

  logic signed [tatpd_pkg::DatW-1:0] px_nxt;
  logic signed [tatpd_pkg::DatW-1:0] py_nxt;
  logic [tatpd_pkg::AngW-1:0]        z_nxt;

  // Rotate towards the positive x axis.
  always_comb begin
    if (!py_i[tatpd_pkg::DatW-1]) begin
      px_nxt = px_i + (py_i >>> Step);
      py_nxt = py_i - (px_i >>> Step);
      z_nxt  = z_i + tatpd_pkg::atan_turn(Idx);
    end else begin
      px_nxt = px_i - (py_i >>> Step);
      py_nxt = py_i + (px_i >>> Step);
      z_nxt  = z_i - tatpd_pkg::atan_turn(Idx);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      px_r <= px_nxt;
      py_r <= py_nxt;
      z_r  <= z_nxt;
    end
  end

endmodule

// ===== hdl/tatpd_rot_stage.sv =====
// One rotating CORDIC iteration with its pipeline register, three lanes.
module tatpd_rot_stage #(
  parameter int Step = 0
) (
  input  logic                              clk,
  input  logic                              adv,
  input  logic signed [tatpd_pkg::DatW-1:0] x_i [3],
  input  logic signed [tatpd_pkg::DatW-1:0] y_i [3],
  input  logic signed [tatpd_pkg::AngW:0]   r_i [3],
  output logic signed [tatpd_pkg::DatW-1:0] x_r [3],
  output logic signed [tatpd_pkg::DatW-1:0] y_r [3],
  output logic signed [tatpd_pkg::AngW:0]   r_r [3]
);

  localparam logic [4:0] Idx = 5'(Step);

  logic signed [tatpd_pkg::DatW-1:0] x_nxt [3];
  logic signed [tatpd_pkg::DatW-1:0] y_nxt [3];
  logic signed [tatpd_pkg::AngW:0]   r_nxt [3];
  logic signed [tatpd_pkg::AngW:0]   a_w;

  assign a_w = {1'b0, tatpd_pkg::atan_turn(Idx)};

  // Drive the residual angle towards zero in each lane.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (!r_i[k][tatpd_pkg::AngW]) begin
        x_nxt[k] = x_i[k] - (y_i[k] >>> Step);
        y_nxt[k] = y_i[k] + (x_i[k] >>> Step);
        r_nxt[k] = r_i[k] - a_w;
      end else begin
        x_nxt[k] = x_i[k] + (y_i[k] >>> Step);
        y_nxt[k] = y_i[k] - (x_i[k] >>> Step);
        r_nxt[k] = r_i[k] + a_w;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      r_r <= r_nxt;
    end
  end

endmodule

// ===== dv/testbench.sv =====
module testbench;

  localparam int SampleBits = 12;
  localparam int DutyBits   = 8;
  localparam int AngleSteps = 16;
  localparam int InW        = ((2*SampleBits+7)/8)*8;
  localparam int OutW       = ((3*DutyBits+7)/8)*8;
  localparam int Latency    = 2*AngleSteps+5;
  localparam int RandItems  = 1200;

  localparam logic [31:0] AtanStep [24] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
  };

  // Duty predictor and store of expected duty triples.
  class duty_scoreboard;
    logic [OutW-1:0] duty_q[$];
    bit              square_on = 1'b1;
    int              errors = 0;
    int              results = 0;

    // Tilt angle as a 32-bit fraction of a turn, vectoring CORDIC.
    function automatic logic [31:0] tilt_turn(longint a, longint b);
      longint px, py, tx;
      logic [31:0] z;
      px = b * 64'sd1073741824;
      py = a * 64'sd1073741824;
      z = '0;
      if (a == 0 && b == 0) return '0;
      if (px < 0) begin
        px = -px;
        py = -py;
        z = 32'h8000_0000;
      end
      for (int i = 0; i < AngleSteps && i < 24; i++) begin
        tx = px;
        if (py >= 0) begin
          px = px + (py >>> i);
          py = py - (tx >>> i);
          z = z + AtanStep[i];
        end else begin
          px = px - (py >>> i);
          py = py + (tx >>> i);
          z = z - AtanStep[i];
        end
      end
      return z;
    endfunction

    // Sine in Q1.15 of a turn fraction, rotating CORDIC.
    function automatic longint phase_sine(logic [31:0] z);
      longint x, y, r, s, tx;
      logic [31:0] d;
      x = 64'sd2608131496;
      y = 0;
      d = z - 32'h4000_0000;
      if (d < 32'h8000_0000) z = 32'h8000_0000 - z;
      r = (z < 32'h8000_0000) ? longint'(z) : longint'(z) - 64'sd4294967296;
      for (int i = 0; i < AngleSteps && i < 24; i++) begin
        tx = x;
        if (r >= 0) begin
          x = x - (y >>> i);
          y = y + (tx >>> i);
          r = r - longint'(AtanStep[i]);
        end else begin
          x = x + (y >>> i);
          y = y - (tx >>> i);
          r = r + longint'(AtanStep[i]);
        end
      end
      s = (y + 64'sd65536) >>> 17;
      if (s > 32767) s = 32767;
      if (s < -32768) s = -32768;
      return s;
    endfunction

    function automatic logic [DutyBits-1:0] phase_duty(logic [31:0] z);
      longint m, v, dmax;
      dmax = (64'sd1 << DutyBits) - 1;
      m = 32768 + phase_sine(z);
      if (square_on) v = (m * m * dmax + 64'sd2147483648) >>> 32;
      else v = (m * dmax + 64'sd32768) >>> 16;
      if (v > dmax) v = dmax;
      return v[DutyBits-1:0];
    endfunction

    // Note an accepted sample pair and queue its duty triple.
    function void note_sample(longint a, longint b);
      logic [31:0] t, base;
      t = tilt_turn(a, b) + 32'h8000;
      base = {t[31:16], 16'h0000};
      duty_q.push_back({phase_duty(base + 32'd2863311531),
                        phase_duty(base + 32'd1431655765), phase_duty(base)});
    endfunction

    // Check an accepted duty triple against the oldest expectation.
    function void check_duty(logic [OutW-1:0] got);
      logic [OutW-1:0] want;
      results++;
      if (duty_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected item %h", got);
        return;
      end
      want = duty_q.pop_front();
      for (int f = 0; f < 3; f++) begin
        if (got[f*DutyBits +: DutyBits] !== want[f*DutyBits +: DutyBits]) begin
          errors++;
          if (errors <= 10)
            $display("duty field %0d mismatch: expected %0d, got %0d", f,
                     want[f*DutyBits +: DutyBits], got[f*DutyBits +: DutyBits]);
        end
      end
    endfunction
  endclass

  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            in_tvalid = 1'b0;
  logic            in_tready;
  logic [InW-1:0]  in_tdata = '0;
  logic            out_tvalid;
  logic            out_tready = 1'b0;
  logic [OutW-1:0] out_tdata;
  logic            cfg_we = 1'b0;
  logic            cfg_wdata = 1'b0;

  duty_scoreboard sb = new();
  bit  calm = 1'b0;
  bit  hold_req = 1'b0;
  int  sent = 0;

  tilt_angle_to_three_phase_duty #(
    .SAMPLE_BITS(SampleBits), .DUTY_BITS(DutyBits), .ANGLE_STEPS(AngleSteps)
  ) dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  // Clock, period 10.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Monitor both channels and the register port at the rising edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) sb.square_on = cfg_wdata;
      if (in_tvalid && in_tready)
        sb.note_sample($signed(in_tdata[SampleBits-1:0]),
                       $signed(in_tdata[2*SampleBits-1:SampleBits]));
      if (out_tvalid && out_tready) sb.check_duty(out_tdata);
    end
  end

  // Receiver: random back-pressure, calm stretches and one long hold-off.
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (300) @(negedge clk);
        hold_req = 1'b0;
        out_tready <= 1'b1;
      end else begin
        out_tready <= calm ? 1'b1 : ($urandom_range(99) >= 27);
      end
    end
  end

  // Offer one sample pair and wait for it to be taken; valid stays high
  // so that the next item can follow without a gap.
  task automatic send_pair(int a, int b);
    logic [SampleBits-1:0] ax, by;
    while (!calm && $urandom_range(99) < 27) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    ax = SampleBits'(a);
    by = SampleBits'(b);
    in_tvalid <= 1'b1;
    in_tdata <= InW'({by, ax});
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    sent++;
  endtask

  // Withdraw the input after a burst of items.
  task automatic end_burst();
    in_tvalid <= 1'b0;
    @(negedge clk);
  endtask

  // Drain all expected items, let the pipeline settle, then write the register.
  task automatic set_curve(bit sq);
    while (sb.duty_q.size() != 0) @(negedge clk);
    repeat (Latency + 4) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= sq;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_phase(int n);
    int a, b, k;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(9);
      if (k < 6) begin
        a = $urandom_range(4095) - 2048;
        b = $urandom_range(4095) - 2048;
      end else if (k < 8) begin
        a = $urandom_range(8) - 4;
        b = $urandom_range(8) - 4;
      end else begin
        a = $urandom_range(1) ? 2047 : -2048;
        b = $urandom_range(4095) - 2048;
        if ($urandom_range(1)) begin
          k = a; a = b; b = k;
        end
      end
      send_pair(a, b);
    end
    end_burst();
  endtask

  int dir_x [16] = '{0, 2047, -2048, 0, 0, 2047, -2048, 2047, -2048,
                     1, 0, -1, 0, -1, 1, -1};
  int dir_y [16] = '{0, 0, 0, 2047, -2048, 2047, -2048, -2048, 2047,
                     0, 1, 0, -1, -1, -1, 1};

  // Main sequence.
  initial begin
    int waited;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed corners with the reset curve, then linear.
    for (int i = 0; i < 16; i++) send_pair(dir_x[i], dir_y[i]);
    end_burst();
    set_curve(1'b0);
    for (int i = 0; i < 16; i++) send_pair(dir_x[i], dir_y[i]);
    end_burst();

    // Random phases across both curve settings.
    random_phase(250);
    set_curve(1'b1);
    calm = 1'b1;
    random_phase(200);
    calm = 1'b0;
    hold_req = 1'b1;
    random_phase(150);
    while (sb.duty_q.size() != 0) @(negedge clk);
    random_phase(150);
    set_curve(1'b0);
    random_phase(250);
    set_curve(1'b1);
    random_phase(200);

    // Drain and settle.
    waited = 0;
    while (sb.duty_q.size() != 0 && waited < 20000) begin
      @(negedge clk);
      waited++;
    end
    repeat (Latency + 10) @(negedge clk);
    if (sb.duty_q.size() != 0) begin
      sb.errors++;
      $display("%0d expected items never arrived", sb.duty_q.size());
    end
    $display("Sent %0d tilt samples, checked %0d duty items over both curves,",
             sent, sb.results);
    $display("with corners, back-pressure, a long output hold-off and a drain pause.");
    if (sb.errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #3000000;
    $display("testbench: errors");
    $finish;
  end

endmodule
